// ===== src/glo_pkg.sv =====
package glo_pkg;

  localparam int FIELD_W = 64;

  typedef enum logic [1:0] {
    OP_GCD   = 2'd0,
    OP_LCM   = 2'd1,
    OP_ORDER = 2'd2,
    OP_MOD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_DIVZERO  = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

endpackage

// ===== src/glo_div.sv =====
module glo_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]  d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    trial;
  logic          fits;

  assign trial = {rem, quo[W-1]};
  assign fits  = trial >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        d    <= divisor;
      end else if (busy) begin
        rem <= fits ? W'(trial - {1'b0, d}) : trial[W-1:0];
        quo <= {quo[W-2:0], fits};
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/glo_mul.sv =====
module glo_mul #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] mcand,
  input  logic [W-1:0] mplier,
  output logic         done,
  output logic [W-1:0] prod,
  output logic         ovf
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]  mq;
  logic [W-1:0]  mb;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W+1:0]  sum;

  assign sum = {1'b0, prod, 1'b0} + (mq[W-1] ? {2'b00, mb} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        prod <= '0;
        ovf  <= 1'b0;
        mq   <= mplier;
        mb   <= mcand;
      end else if (busy) begin
        prod <= sum[W-1:0];
        ovf  <= ovf | prod[W-1] | sum[W+1] | sum[W];
        mq   <= {mq[W-2:0], 1'b0};
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/gcd_lcm_order_unit.sv =====
// One item at a time: gcd, lcm, additive order or modulo of two unsigned operands, of which
// the low DATA_WIDTH bits are used. Each Euclid step and the final divide run on a bit-serial
// divider, and the lcm multiply runs on a bit-serial multiplier; in_stall stays high until the
// item's result is loaded into the output register.
// Errors give result 0: 1 for divide by zero, 2 for lcm overflow.
module gcd_lcm_order_unit #(
  parameter int DATA_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [63:0] operand_a,
  input  logic [63:0] operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result,
  output logic [1:0]  error
);

  localparam int W  = DATA_WIDTH;
  localparam int FW = glo_pkg::FIELD_W;

  typedef enum logic [2:0] {
    S_IDLE, S_GCD, S_GCD_WAIT, S_DIV_WAIT, S_MUL_WAIT, S_FIN
  } state_t;

  state_t         state;
  glo_pkg::op_t   op;
  glo_pkg::err_t  err;
  logic [W-1:0]   a, b, x, y, res;
  logic [W-1:0]   in_a, in_b;
  glo_pkg::op_t   in_op;

  logic           div_start, div_done, mul_start, mul_done, mul_ovf;
  logic [W-1:0]   div_n, div_d, div_quo, div_rem, mul_prod;

  assign in_a     = operand_a[W-1:0];
  assign in_b     = operand_b[W-1:0];
  assign in_op    = glo_pkg::op_t'(opcode);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    div_start = 1'b0;
    div_n     = y;
    div_d     = x;
    mul_start = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_op == glo_pkg::OP_MOD && in_b != '0) begin
          div_start = 1'b1;
          div_n     = in_a;
          div_d     = in_b;
        end
      end
      S_GCD: begin
        if (x != '0) begin
          div_start = 1'b1;
        end else if (op == glo_pkg::OP_LCM && y != '0) begin
          div_start = 1'b1;
          div_n     = a;
          div_d     = y;
        end else if (op == glo_pkg::OP_ORDER) begin
          div_start = 1'b1;
          div_n     = b;
          div_d     = y;
        end
      end
      S_DIV_WAIT: mul_start = div_done && op == glo_pkg::OP_LCM;
      default: ;
    endcase
  end

  glo_div #(.W(W)) u_div (
    .clk, .rst, .start(div_start), .dividend(div_n), .divisor(div_d),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  glo_mul #(.W(W)) u_mul (
    .clk, .rst, .start(mul_start), .mcand(b), .mplier(div_quo),
    .done(mul_done), .prod(mul_prod), .ovf(mul_ovf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op  <= in_op;
            a   <= in_a;
            b   <= in_b;
            x   <= in_a;
            y   <= in_b;
            res <= '0;
            err <= glo_pkg::ERR_NONE;
            priority if (in_op == glo_pkg::OP_ORDER && in_a == '0) begin
              res   <= W'(1);
              state <= S_FIN;
            end else if (in_op == glo_pkg::OP_MOD) begin
              if (in_b == '0) begin
                err   <= glo_pkg::ERR_DIVZERO;
                state <= S_FIN;
              end else begin
                state <= S_DIV_WAIT;
              end
            end else begin
              state <= S_GCD;
            end
          end
        end
        S_GCD: begin
          priority if (x != '0) begin
            state <= S_GCD_WAIT;
          end else if (op == glo_pkg::OP_GCD) begin
            res   <= y;
            state <= S_FIN;
          end else if (op == glo_pkg::OP_LCM && y == '0) begin
            err   <= glo_pkg::ERR_DIVZERO;
            state <= S_FIN;
          end else begin
            state <= S_DIV_WAIT;
          end
        end
        S_GCD_WAIT: begin
          if (div_done) begin
            y     <= x;
            x     <= div_rem;
            state <= S_GCD;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            unique case (op)
              glo_pkg::OP_MOD: begin
                res   <= div_rem;
                state <= S_FIN;
              end
              glo_pkg::OP_ORDER: begin
                res   <= div_quo;
                state <= S_FIN;
              end
              glo_pkg::OP_LCM: state <= S_MUL_WAIT;
              default:         state <= S_FIN;
            endcase
          end
        end
        S_MUL_WAIT: begin
          if (mul_done) begin
            if (mul_ovf) begin
              err <= glo_pkg::ERR_OVERFLOW;
            end else begin
              res <= mul_prod;
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            result    <= FW'(res);
            error     <= err;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
